### rtl/pfc_pkg.sv
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned NUM_CELLS   = 25;
  localparam int unsigned SIDE        = 5;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_A     = 8'd97;
  localparam logic [7:0] CHAR_Z     = 8'd122;
  localparam logic [7:0] SPACE_BYTE = 8'd32;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_I    = 5'd8;
  localparam letter_t LETTER_J    = 5'd9;
  localparam letter_t LETTER_X    = 5'd23;
  localparam letter_t LETTER_LAST = letter_t'(NUM_LETTERS - 1);
  localparam cell_t   CELLS_FULL  = cell_t'(NUM_CELLS);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_ODD_TAIL = 2'd2;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_MSG   = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  // one classified item as it sits in the queue
  typedef struct packed {
    cmd_e    cmd;
    logic    usable;  // key: lowercase and not j; message: lowercase
    logic    space;
    letter_t letter;  // j already folded to i for message bytes
  } op_t;

  function automatic coord_t cell_row(input cell_t c);
    coord_t r;
    if (c >= 5'd20) begin
      r = 3'd4;
    end else if (c >= 5'd15) begin
      r = 3'd3;
    end else if (c >= 5'd10) begin
      r = 3'd2;
    end else if (c >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic coord_t cell_col(input cell_t c);
    coord_t r;
    cell_t  d;
    r = cell_row(c);
    d = c - cell_t'({r, 2'b00}) - cell_t'(r);
    return d[2:0];
  endfunction

  function automatic cell_t cell_at(input coord_t row, input coord_t col);
    return cell_t'({row, 2'b00}) + cell_t'(row) + cell_t'(col);
  endfunction

  // forward or backward step around a row or column
  function automatic coord_t step5(input coord_t v, input logic back);
    coord_t r;
    if (back) begin
      r = (v == 3'd0) ? coord_t'(SIDE - 1) : v - 3'd1;
    end else begin
      r = (v == coord_t'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage

### rtl/pfc_in_if.sv
`timescale 1ns / 1ps

interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] byte_value;

  modport source (output valid, output command, output byte_value, input ready);
  modport sink (input valid, input command, input byte_value, output ready);
endinterface

### rtl/pfc_out_if.sv
`timescale 1ns / 1ps

interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] first_letter;
  logic [4:0] second_letter;
  logic [1:0] status;
  logic       last_pair;

  modport source (output valid, output first_letter, output second_letter,
                  output status, output last_pair, input ready);
  modport sink (input valid, input first_letter, input second_letter,
                input status, input last_pair, output ready);
endinterface

### rtl/pfc_front.sv
`timescale 1ns / 1ps

module pfc_front (
  pfc_in_if.sink        in_i,
  output logic          push_o,
  output pfc_pkg::op_t  push_data_o,
  input  logic          push_ready_i
);
  import pfc_pkg::*;

  logic       lower;
  logic [7:0] diff;
  letter_t    raw;
  cmd_e       cmd;

  assign cmd   = cmd_e'(in_i.command);
  assign lower = (in_i.byte_value >= CHAR_A) && (in_i.byte_value <= CHAR_Z);
  assign diff  = in_i.byte_value - CHAR_A;
  assign raw   = lower ? diff[4:0] : '0;

  always_comb begin
    push_data_o.cmd    = cmd;
    push_data_o.space  = (in_i.byte_value == SPACE_BYTE);
    push_data_o.usable = 1'b0;
    push_data_o.letter = raw;
    case (cmd)
      CMD_KEY: begin
        push_data_o.usable = lower && (raw != LETTER_J);
      end
      CMD_MSG: begin
        push_data_o.usable = lower;
        push_data_o.letter = (raw == LETTER_J) ? LETTER_I : raw;
      end
      default: begin
        push_data_o.usable = 1'b0;
      end
    endcase
  end

  assign in_i.ready = push_ready_i;
  assign push_o     = in_i.valid && push_ready_i;

endmodule

### rtl/pfc_queue.sv
`timescale 1ns / 1ps

module pfc_queue #(
  parameter int unsigned Depth = pfc_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pfc_pkg::op_t  push_data_i,
  output logic          push_ready_o,
  input  logic          pop_i,
  output pfc_pkg::op_t  pop_data_o,
  output logic          pop_valid_o
);
  import pfc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  op_t             slot_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/pfc_back.sv
`timescale 1ns / 1ps

module pfc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  pfc_pkg::op_t  op_i,
  input  logic          op_valid_i,
  output logic          pop_o,
  pfc_out_if.source     out_o
);
  import pfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_LOOK = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [NUM_LETTERS-1:0] present_q, present_d, present_eff;
  cell_t                  fill_q, fill_d, fill_eff;
  letter_t                held_q, held_d;
  logic                   held_valid_q, held_valid_d;
  logic                   phase_q, phase_d;
  logic                   decrypt_q;
  letter_t                walk_q, walk_d;
  logic                   last_q, last_d;

  // key square and reverse map
  letter_t key_square_q [NUM_CELLS];
  cell_t   letter_cell_q [NUM_LETTERS];
  cell_t   cell_a_q, cell_b_q;
  letter_t sq_a_q, sq_b_q;

  logic    place_en;
  letter_t place_l;
  cell_t   place_at;
  logic    rd_cell_en, rd_sq_en;
  letter_t rd_a, rd_b;
  cell_t   na, nb;
  coord_t  ra, ca, rb, cb;

  logic       out_valid_q, out_valid_d;
  letter_t    out_first_q, out_first_d;
  letter_t    out_second_q, out_second_d;
  logic [1:0] out_status_q, out_status_d;
  logic       out_last_q, out_last_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_o.ready;

  assign ra = cell_row(cell_a_q);
  assign ca = cell_col(cell_a_q);
  assign rb = cell_row(cell_b_q);
  assign cb = cell_col(cell_b_q);

  always_comb begin
    state_d      = state_q;
    present_d    = present_q;
    fill_d       = fill_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    phase_d      = phase_q;
    walk_d       = walk_q;
    last_d       = last_q;
    place_en     = 1'b0;
    place_l      = op_i.letter;
    place_at     = fill_q;
    rd_cell_en   = 1'b0;
    rd_a         = held_q;
    rd_b         = LETTER_X;
    rd_sq_en     = 1'b0;
    na           = cell_at(ra, cb);
    nb           = cell_at(rb, ca);
    pop_o        = 1'b0;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    // a new key forgets the old square
    present_eff  = phase_q ? '0 : present_q;
    fill_eff     = phase_q ? '0 : fill_q;

    case (state_q)
      S_IDLE: begin
        if (op_valid_i && out_free) begin
          pop_o = 1'b1;
          case (op_i.cmd)
            CMD_KEY: begin
              present_d = present_eff;
              fill_d    = fill_eff;
              if (phase_q) begin
                held_valid_d = 1'b0;
                phase_d      = 1'b0;
              end
              if (op_i.usable && !present_eff[op_i.letter] && (fill_eff < CELLS_FULL)) begin
                place_en                = 1'b1;
                place_l                 = op_i.letter;
                place_at                = fill_eff;
                present_d[op_i.letter]  = 1'b1;
                fill_d                  = fill_eff + 5'd1;
              end
            end
            CMD_CLOSE: begin
              if (!phase_q) begin
                walk_d  = '0;
                state_d = S_FILL;
              end
            end
            CMD_MSG: begin
              if (phase_q && !op_i.space) begin
                if (!op_i.usable) begin
                  out_valid_d  = 1'b1;
                  out_first_d  = '0;
                  out_second_d = '0;
                  out_status_d = STATUS_BAD_CHAR;
                  out_last_d   = 1'b0;
                end else if (!held_valid_q) begin
                  held_d       = op_i.letter;
                  held_valid_d = 1'b1;
                end else if (!decrypt_q && (op_i.letter == held_q)) begin
                  // doubled pair: pad with x, the letter stays held
                  rd_cell_en = 1'b1;
                  rd_b       = LETTER_X;
                  last_d     = 1'b0;
                  held_d     = op_i.letter;
                  state_d    = S_LOOK;
                end else begin
                  rd_cell_en   = 1'b1;
                  rd_b         = op_i.letter;
                  last_d       = 1'b0;
                  held_valid_d = 1'b0;
                  state_d      = S_LOOK;
                end
              end
            end
            CMD_END: begin
              if (phase_q && held_valid_q) begin
                held_valid_d = 1'b0;
                if (decrypt_q) begin
                  out_valid_d  = 1'b1;
                  out_first_d  = held_q;
                  out_second_d = '0;
                  out_status_d = STATUS_ODD_TAIL;
                  out_last_d   = 1'b1;
                end else begin
                  rd_cell_en = 1'b1;
                  rd_b       = LETTER_X;
                  last_d     = 1'b1;
                  state_d    = S_LOOK;
                end
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        place_l  = walk_q;
        place_at = fill_q;
        if ((walk_q != LETTER_J) && !present_q[walk_q] && (fill_q < CELLS_FULL)) begin
          place_en          = 1'b1;
          present_d[walk_q] = 1'b1;
          fill_d            = fill_q + 5'd1;
        end
        if (walk_q == LETTER_LAST) begin
          held_valid_d = 1'b0;
          phase_d      = 1'b1;
          state_d      = S_IDLE;
        end else begin
          walk_d = walk_q + 5'd1;
        end
      end
      S_LOOK: begin
        rd_sq_en = 1'b1;
        if (ra == rb) begin
          na = cell_at(ra, step5(ca, decrypt_q));
          nb = cell_at(rb, step5(cb, decrypt_q));
        end else if (ca == cb) begin
          na = cell_at(step5(ra, decrypt_q), ca);
          nb = cell_at(step5(rb, decrypt_q), cb);
        end else begin
          na = cell_at(ra, cb);
          nb = cell_at(rb, ca);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_first_d  = sq_a_q;
          out_second_d = sq_b_q;
          out_status_d = STATUS_OK;
          out_last_d   = last_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      present_q    <= '0;
      fill_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      phase_q      <= 1'b0;
      decrypt_q    <= 1'b0;
      walk_q       <= '0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      present_q    <= present_d;
      fill_q       <= fill_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      phase_q      <= phase_d;
      walk_q       <= walk_d;
      last_q       <= last_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        decrypt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (place_en) begin
      key_square_q[place_at] <= place_l;
      letter_cell_q[place_l] <= place_at;
    end
    if (rd_cell_en) begin
      cell_a_q <= letter_cell_q[rd_a];
      cell_b_q <= letter_cell_q[rd_b];
    end
    if (rd_sq_en) begin
      sq_a_q <= key_square_q[na];
      sq_b_q <= key_square_q[nb];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.first_letter  = out_first_q;
  assign out_o.second_letter = out_second_q;
  assign out_o.status        = out_status_q;
  assign out_o.last_pair     = out_last_q;

endmodule

### rtl/playfair_digraph_cipher_top.sv
// a pair result passes the letter-to-cell read and the square read into the output
//   register; a flagged character or odd-tail status goes straight to that register
// throughput: 1 item per cycle for key bytes, spaces and held letters while the
//   output register is free; none is taken during pair reads or the close alphabet walk
// reset clears control state, the queue and the output valid; the square must be rebuilt
`timescale 1ns / 1ps

module playfair_digraph_cipher_top #(
  parameter int unsigned QueueDepth = pfc_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  pfc_in_if.sink     in_i,
  pfc_out_if.source  out_o
);
  import pfc_pkg::*;

  logic push;
  op_t  push_data;
  logic push_ready;
  logic pop;
  op_t  pop_data;
  logic pop_valid;

  pfc_front u_front (
    .in_i         (in_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  pfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid)
  );

  pfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (pop_data),
    .op_valid_i  (pop_valid),
    .pop_o       (pop),
    .out_o       (out_o)
  );

`ifndef SYNTH
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("queue popped while empty");

  a_odd_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == STATUS_ODD_TAIL)) |-> out_o.last_pair)
    else $error("odd tail status without last pair");

  a_bad_char_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == STATUS_BAD_CHAR)) |->
      (!out_o.last_pair && (out_o.first_letter == '0) && (out_o.second_letter == '0)))
    else $error("bad character result carries letters or last pair");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

import pfc_pkg::*;

typedef struct packed {
  letter_t    first;
  letter_t    second;
  logic [1:0] status;
  logic       last;
} pair_out_t;

class cipher_checker;
  letter_t   square[NUM_CELLS];
  cell_t     cell_of[NUM_LETTERS];
  bit        present[NUM_LETTERS];
  int        filled;
  letter_t   held;
  bit        held_v;
  bit        msg_open;
  bit        decrypt;
  pair_out_t expected_pairs[$];
  int        mismatches;

  function new();
    foreach (present[l]) present[l] = 1'b0;
    filled     = 0;
    held       = '0;
    held_v     = 1'b0;
    msg_open   = 1'b0;
    decrypt    = 1'b0;
    mismatches = 0;
  endfunction

  function void set_mode(input bit m);
    decrypt = m;
  endfunction

  function int pending();
    return expected_pairs.size();
  endfunction

  function void add_expected(input pair_out_t r);
    expected_pairs.insert(expected_pairs.size(), r);
  endfunction

  function void place(input int l);
    if (l >= NUM_LETTERS || l == LETTER_J || present[l] || filled >= NUM_CELLS) begin
      return;
    end
    square[filled] = letter_t'(l);
    cell_of[l]     = cell_t'(filled);
    present[l]     = 1'b1;
    filled++;
  endfunction

  function pair_out_t status_only(input letter_t f, input logic [1:0] st, input logic last);
    pair_out_t r;
    r.first  = f;
    r.second = '0;
    r.status = st;
    r.last   = last;
    return r;
  endfunction

  function pair_out_t cipher_pair(input letter_t a, input letter_t b, input logic last);
    int ca, cb, r1, c1, r2, c2, s, na, nb;
    pair_out_t r;
    ca = cell_of[a];
    cb = cell_of[b];
    r1 = ca / SIDE;
    c1 = ca % SIDE;
    r2 = cb / SIDE;
    c2 = cb % SIDE;
    s  = decrypt ? SIDE - 1 : 1;
    if (r1 == r2) begin
      na = r1 * SIDE + (c1 + s) % SIDE;
      nb = r2 * SIDE + (c2 + s) % SIDE;
    end else if (c1 == c2) begin
      na = ((r1 + s) % SIDE) * SIDE + c1;
      nb = ((r2 + s) % SIDE) * SIDE + c2;
    end else begin
      // rectangle: swap columns
      na = r1 * SIDE + c2;
      nb = r2 * SIDE + c1;
    end
    r.first  = square[na];
    r.second = square[nb];
    r.status = STATUS_OK;
    r.last   = last;
    return r;
  endfunction

  function void take_item(input cmd_e cmd, input logic [7:0] b);
    int l;
    case (cmd)
      CMD_KEY: begin
        // a key byte after close starts a new square
        if (msg_open) begin
          foreach (present[k]) present[k] = 1'b0;
          filled   = 0;
          held_v   = 1'b0;
          msg_open = 1'b0;
        end
        if (b >= CHAR_A && b <= CHAR_Z) begin
          place(b - CHAR_A);
        end
      end
      CMD_CLOSE: begin
        if (!msg_open) begin
          for (int k = 0; k < NUM_LETTERS; k++) place(k);
          held_v   = 1'b0;
          msg_open = 1'b1;
        end
      end
      CMD_END: begin
        if (msg_open && held_v) begin
          held_v = 1'b0;
          if (decrypt) begin
            add_expected(status_only(held, STATUS_ODD_TAIL, 1'b1));
          end else begin
            add_expected(cipher_pair(held, LETTER_X, 1'b1));
          end
        end
      end
      CMD_MSG: begin
        if (msg_open && b != SPACE_BYTE) begin
          if (b < CHAR_A || b > CHAR_Z) begin
            add_expected(status_only('0, STATUS_BAD_CHAR, 1'b0));
          end else begin
            l = b - CHAR_A;
            if (l == LETTER_J) l = LETTER_I;
            if (!held_v) begin
              held   = letter_t'(l);
              held_v = 1'b1;
            end else if (!decrypt && l == held) begin
              // doubled letter: x goes in between, the letter stays held
              add_expected(cipher_pair(held, LETTER_X, 1'b0));
            end else begin
              add_expected(cipher_pair(held, letter_t'(l), 1'b0));
              held_v = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function void check_pair(input pair_out_t got);
    pair_out_t want;
    if (expected_pairs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: first %0d second %0d status %0d last %0d",
                 got.first, got.second, got.status, got.last);
      end
      return;
    end
    want = expected_pairs.pop_front();
    if (got.first !== want.first || got.second !== want.second ||
        got.status !== want.status || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected %0d %0d status %0d last %0d, got %0d %0d status %0d last %0d",
                 want.first, want.second, want.status, want.last,
                 got.first, got.second, got.status, got.last);
      end
    end
  endfunction
endclass

module tb;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int BLOCK_ITEMS    = 90;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  pfc_in_if  in_if ();
  pfc_out_if out_if ();

  cipher_checker chk = new();

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_done;
  int hold_left;
  int quiet_cycles;
  int block_items;

  playfair_digraph_cipher_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: check, then pick ready for the next edge
  initial begin
    out_if.ready <= 1'b0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        chk.check_pair(pair_out_t'({out_if.first_letter, out_if.second_letter,
                                    out_if.status, out_if.last_pair}));
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_done != hold_req) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input cmd_e cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.byte_value <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    chk.take_item(cmd, b);
    block_items++;
  endtask

  // wait until the block is idle, then write the mode
  task automatic write_mode(input bit m);
    in_if.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    chk.set_mode(m);
  endtask

  task automatic load_key();
    int order[NUM_LETTERS];
    int k, t;
    if ($urandom_range(99) < 12) begin
      // whole alphabet shuffled, so the key alone fills the square
      foreach (order[i]) order[i] = i;
      for (int i = NUM_LETTERS - 1; i > 0; i--) begin
        k = $urandom_range(i);
        t = order[i];
        order[i] = order[k];
        order[k] = t;
      end
      foreach (order[i]) send_item(CMD_KEY, CHAR_A + 8'(order[i]));
      send_item(CMD_KEY, CHAR_A + 8'($urandom_range(25)));
    end else begin
      repeat ($urandom_range(12)) begin
        if ($urandom_range(99) < 85) begin
          send_item(CMD_KEY, CHAR_A + 8'($urandom_range(25)));
        end else begin
          send_item(CMD_KEY, 8'($urandom_range(255)));
        end
      end
    end
    send_item(CMD_CLOSE, 8'($urandom_range(255)));
    if ($urandom_range(99) < 10) send_item(CMD_CLOSE, 8'($urandom_range(255)));
  endtask

  task automatic send_message();
    logic [7:0] prev, b;
    int pick;
    prev = "e";
    repeat ($urandom_range(1, 16)) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        b = prev;
      end else if (pick < 20) begin
        b = "j";
      end else if (pick < 30) begin
        b = SPACE_BYTE;
      end else if (pick < 37) begin
        do b = 8'($urandom_range(255));
        while ((b >= CHAR_A && b <= CHAR_Z) || b == SPACE_BYTE);
      end else begin
        b = CHAR_A + 8'($urandom_range(25));
      end
      send_item(CMD_MSG, b);
      if (b >= CHAR_A && b <= CHAR_Z) prev = b;
    end
    if ($urandom_range(99) < 90) send_item(CMD_END, 8'($urandom_range(255)));
  endtask

  task automatic run_sessions(input int target);
    block_items = 0;
    while (block_items < target) begin
      if ($urandom_range(99) < 8) begin
        send_item(cmd_e'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        load_key();
        repeat ($urandom_range(1, 3)) send_message();
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_KEY;
    in_if.byte_value <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    // message and end before the square is closed do nothing
    send_item(CMD_MSG, "a");
    send_item(CMD_END, 8'd0);
    send_item(CMD_KEY, "z");
    send_item(CMD_KEY, "a");
    send_item(CMD_KEY, "j");
    send_item(CMD_KEY, "a");
    send_item(CMD_KEY, 8'd255);
    send_item(CMD_KEY, "m");
    send_item(CMD_CLOSE, 8'd0);
    send_item(CMD_CLOSE, 8'd255);
    // same row, doubled letter, space dropped
    send_item(CMD_MSG, "h");
    send_item(CMD_MSG, SPACE_BYTE);
    send_item(CMD_MSG, "h");
    send_item(CMD_MSG, "e");
    // j folds to i and doubles with i; bad bytes leave i held
    send_item(CMD_MSG, "j");
    send_item(CMD_MSG, "i");
    send_item(CMD_MSG, 8'd0);
    send_item(CMD_MSG, 8'd123);
    send_item(CMD_MSG, "z");
    // odd tail, then an end with nothing held
    send_item(CMD_MSG, "q");
    send_item(CMD_END, 8'd0);
    send_item(CMD_END, 8'd0);

    write_mode(1'b1);
    send_item(CMD_MSG, "a");
    send_item(CMD_MSG, "a");
    send_item(CMD_MSG, "x");
    send_item(CMD_END, 8'd0);
    send_item(CMD_KEY, "b");
    send_item(CMD_CLOSE, 8'd0);

    for (int p = 0; p < 3; p++) begin
      for (int m = 0; m < 2; m++) begin
        write_mode(m[0]);
        case (p)
          0: begin
            send_idle_pct = 26;
            recv_idle_pct = 70;
          end
          1: begin
            send_idle_pct = 70;
            recv_idle_pct = 26;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        // long receiver stall while items keep coming
        if (p == 2 && m == 0) hold_req <= hold_req + 1;
        run_sessions(BLOCK_ITEMS);
      end
    end

    in_if.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (chk.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
